>>> hdl/lowest_free_id_allocator_core_assert.svh
// Assertion helpers for the id allocator checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef LOWEST_FREE_ID_ALLOCATOR_CORE_ASSERT_SVH
`define LOWEST_FREE_ID_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define LFIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lfia_pkg.sv
package lfia_pkg;

  // Pool sizing
  localparam int NUM_IDS      = 256;
  localparam int BITMAP_BYTES = 32;
  localparam int BITMAP_BITS  = BITMAP_BYTES * 8;
  localparam int POOL_IDS     = (NUM_IDS < BITMAP_BITS) ? NUM_IDS : BITMAP_BITS;

  // Field and index widths
  localparam int KIND_W = 2;
  localparam int ID_W   = 8;
  localparam int IDX_W  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int HINT_W = $clog2(BITMAP_BYTES + 1);

  // Byte patterns
  localparam logic [7:0] BYTE_FULL = 8'hff;
  localparam logic [7:0] BYTE_NONE = 8'h00;

  // Request kinds; the remaining code means nothing and fails
  typedef enum logic [KIND_W-1:0] {
    KIND_OBTAIN   = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_FREE_ALL = 2'd2
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted word
    logic advance;  // step the hint past a fully used byte
    logic commit;   // apply the request and load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_skip;  // obtain sits on a fully used byte
    logic out_free;   // result register can take a word this cycle
  } dp_stat_t;

  // Free mask of one byte after a pool fill
  function automatic logic [7:0] fill_byte(input int idx);
    int base;
    int n;
    base = idx * 8;
    if (base >= POOL_IDS) n = 0;
    else if (POOL_IDS - base >= 8) n = 8;
    else n = POOL_IDS - base;
    return 8'((1 << n) - 1);
  endfunction

  // Position of the lowest set bit, zero when none
  function automatic logic [2:0] lowest_bit(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (b[k]) pos = 3'(k);
    end
    return pos;
  endfunction

endpackage

>>> hdl/lfia_in_if.sv
interface lfia_in_if import lfia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   release_id;

  modport source (output valid, output kind, output release_id, input ready);
  modport sink (input valid, input kind, input release_id, output ready);
  modport monitor (input valid, input kind, input release_id, input ready);
endinterface

>>> hdl/lfia_out_if.sv
interface lfia_out_if import lfia_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            ok;
  logic [ID_W-1:0] granted_id;

  modport source (output valid, output ok, output granted_id, input ready);
  modport sink (input valid, input ok, input granted_id, output ready);
  modport monitor (input valid, input ok, input granted_id, input ready);
endinterface

>>> hdl/lowest_free_id_allocator_core.sv
// Lowest-free id allocator. Each input word is one request: obtain grants the
// lowest free id of the pool and answers ok=0 when all are taken, release frees
// an id and answers ok=0 for one beyond the pool, free-all marks every id free.
// Every request yields exactly one result word. The word is captured on
// acceptance; an obtain then steps the hint past each fully used byte, and
// the request commits once the result register is free; the hint scan reads
// one bitmap byte per cycle. One request is in flight at a time; a finished
// result waits in an output register. The pool is full after reset.
module lowest_free_id_allocator_core import lfia_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  lfia_in_if.sink    in_chan,
  lfia_out_if.source out_chan
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  lfia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfia_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_chan.kind),
    .in_release_id  (in_chan.release_id),
    .out_ready      (out_chan.ready),
    .stat           (stat),
    .out_valid      (out_chan.valid),
    .out_ok         (out_chan.ok),
    .out_granted_id (out_chan.granted_id)
  );

endmodule

>>> hdl/lfia_datapath.sv
module lfia_datapath import lfia_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [ID_W-1:0]   in_release_id,
  input  logic              out_ready,
  output dp_stat_t          stat,
  output logic              out_valid,
  output logic              out_ok,
  output logic [ID_W-1:0]   out_granted_id
);

  kind_t             kind_r;
  logic [ID_W-1:0]   rid_r;
  logic [7:0]        bitmap_r [BITMAP_BYTES];
  logic [7:0]        bitmap_nxt [BITMAP_BYTES];
  logic [HINT_W-1:0] hint_r;
  logic [HINT_W-1:0] hint_nxt;
  logic              out_valid_r;
  logic              out_ok_r;
  logic              ok_nxt;
  logic [ID_W-1:0]   out_gid_r;
  logic [ID_W-1:0]   gid_nxt;

  logic              hint_ok;
  logic [IDX_W-1:0]  hint_idx;
  logic [7:0]        cur_byte;
  logic [2:0]        low_bit;
  logic [31:0]       gid_full;
  logic [31:0]       rid_full;
  logic              rel_ok;
  logic [IDX_W-1:0]  rel_idx;

  // Look at the byte under the hint
  assign hint_ok  = hint_r < HINT_W'(BITMAP_BYTES);
  assign hint_idx = IDX_W'(hint_r);
  assign cur_byte = hint_ok ? bitmap_r[hint_idx] : BYTE_NONE;
  assign low_bit  = lowest_bit(cur_byte);
  assign gid_full = (32'(hint_r) << 3) | 32'(low_bit);

  // Decode the release id
  assign rid_full = 32'(rid_r);
  assign rel_ok   = rid_full < 32'(POOL_IDS);
  assign rel_idx  = IDX_W'(rid_full >> 3);

  assign stat.need_skip = (kind_r == KIND_OBTAIN) && hint_ok && (cur_byte == BYTE_NONE);
  assign stat.out_free  = !out_valid_r || out_ready;

  // Work out the effect of the held request
  always_comb begin
    bitmap_nxt = bitmap_r;
    hint_nxt   = hint_r;
    ok_nxt     = 1'b0;
    gid_nxt    = '0;
    if (cmd.advance) begin
      hint_nxt = hint_r + HINT_W'(1);
    end else if (cmd.commit) begin
      case (kind_r)
        KIND_OBTAIN: begin
          if (hint_ok) begin
            bitmap_nxt[hint_idx] = cur_byte & ~(8'h01 << low_bit);
            ok_nxt               = 1'b1;
            gid_nxt              = gid_full[ID_W-1:0];
          end
        end
        KIND_RELEASE: begin
          if (rel_ok) begin
            bitmap_nxt[rel_idx] = bitmap_r[rel_idx] | (8'h01 << rid_r[2:0]);
            if (32'(rel_idx) < 32'(hint_r)) hint_nxt = HINT_W'(rel_idx);
            ok_nxt = 1'b1;
          end
        end
        KIND_FREE_ALL: begin
          for (int i = 0; i < BITMAP_BYTES; i++) bitmap_nxt[i] = fill_byte(i);
          hint_nxt = '0;
          ok_nxt   = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // Hold the bitmap and hint; reset fills the pool
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BITMAP_BYTES; i++) bitmap_r[i] <= fill_byte(i);
      hint_r <= '0;
    end else begin
      bitmap_r <= bitmap_nxt;
      hint_r   <= hint_nxt;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_t'(in_kind);
      rid_r  <= in_release_id;
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok_r  <= ok_nxt;
      out_gid_r <= gid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_granted_id = out_gid_r;

endmodule

>>> hdl/lfia_ctrl.sv
module lfia_ctrl import lfia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Sequence one request: capture, skip used bytes, commit
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.need_skip) begin
          cmd.advance = 1'b1;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/lfia_checker.sv
`include "lowest_free_id_allocator_core_assert.svh"

module lfia_checker import lfia_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_ok,
  input logic [ID_W-1:0] out_granted_id
);

  // Stalled result word holds
  `LFIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ok) && $stable(out_granted_id), "result word changed while stalled")

  // Failed results carry a zero id
  `LFIA_ASSERT_NOW(a_fail_zero_id, out_valid && !out_ok, out_granted_id == '0, "failed result with nonzero id")

  // Accepted request keeps the block busy next cycle
  `LFIA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready right after accepting a word")

endmodule

bind lowest_free_id_allocator_core lfia_checker u_lfia_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_ok         (out_chan.ok),
  .out_granted_id (out_chan.granted_id)
);
